// ===== rtl/arp_pkg.sv =====
`timescale 1ns / 1ps
package arp_pkg;
	localparam int TableEntries = 8;
	localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
	localparam int CntW = $clog2(TableEntries + 1);
	localparam int MaxResults = 8;
	localparam int ResW = $clog2(MaxResults + 1);
	localparam logic [15:0] LruStart = 16'hffff;

	typedef enum logic [1:0] {
		ST_FREE = 2'd0,
		ST_RESOLVING = 2'd1,
		ST_OK = 2'd2,
		ST_UNUSED = 2'd3
	} entry_state_t;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_LEARN = 2'd1,
		CMD_RESOLVE = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_REQUEST = 2'd1,
		KIND_REPLY = 2'd2,
		KIND_RESOLVED = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_LOCAL_IP = 3'd0,
		REG_NET_MASK = 3'd1,
		REG_GATEWAY_IP = 3'd2,
		REG_OK_TIMEOUT = 3'd3,
		REG_PENDING_TIMEOUT = 3'd4,
		REG_MAX_RETRIES = 3'd5
	} reg_t;

	localparam logic [15:0] HwEthernet = 16'd1;
	localparam logic [15:0] OpRequest = 16'd1;
	localparam logic [15:0] OpReply = 16'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [15:0] hw_type;
		logic [15:0] arp_op;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [31:0] tgt_ip;
		logic [31:0] dest_ip;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] addr;
		logic [47:0] hw_addr;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] local_ip;
		logic [31:0] net_mask;
		logic [31:0] gateway_ip;
		logic [15:0] ok_timeout;
		logic [15:0] pending_timeout;
		logic [7:0] max_retries;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;         // capture input item
		logic scan;         // examine entry at idx
		logic [IdxW-1:0] idx;
		logic write_learn;  // write learned sender into chosen slot
		logic emit;         // take the request held in datapath
		logic finish;       // produce final result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic accepted;     // learn packet passes filters
		logic is_request;
		logic is_learn_op;
		logic emit_ready;   // scanned entry produced a request, held until taken
	} dp_status_t;
endpackage

// ===== rtl/arp_if.sv =====
`timescale 1ns / 1ps
interface arp_in_if (input logic clk);
	import arp_pkg::*;
	logic valid;
	logic ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface arp_out_if (input logic clk);
	import arp_pkg::*;
	logic valid;
	logic ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface arp_cfg_if (input logic clk);
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/arp_datapath.sv =====
`timescale 1ns / 1ps
module arp_datapath (
	input logic clk,
	input logic arst_n,
	input arp_pkg::in_item_t in_data,
	input arp_pkg::cfg_t cfg,
	input arp_pkg::dp_cmd_t cmd_i,
	output arp_pkg::dp_status_t status,
	output arp_pkg::out_item_t res
);
	import arp_pkg::*;

	entry_state_t state_q [TableEntries];
	logic [31:0] ip_q [TableEntries];
	logic [47:0] mac_q [TableEntries];
	logic [15:0] timer_q [TableEntries];
	logic [7:0] retries_q [TableEntries];

	in_item_t item_q;
	logic [31:0] hop_q;
	logic found_q, free_found_q, hit_q;
	logic [IdxW-1:0] found_idx_q, free_idx_q, lru_idx_q;
	logic [15:0] lru_timer_q;
	logic [1:0] res_kind_q;
	logic [31:0] res_addr_q;
	logic [47:0] res_mac_q;
	logic emit_q;

	entry_state_t st;
	logic [31:0] eip;
	logic [IdxW-1:0] slot;

	assign st = state_q[cmd_i.idx];
	assign eip = ip_q[cmd_i.idx];
	assign slot = found_q ? found_idx_q : (free_found_q ? free_idx_q : lru_idx_q);

	// entry table, sweep state and result holding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TableEntries; i++) begin
				state_q[i] <= ST_FREE;
				ip_q[i] <= '0;
				mac_q[i] <= '0;
				timer_q[i] <= '0;
				retries_q[i] <= '0;
			end
			item_q <= '0;
			hop_q <= '0;
			emit_q <= 1'b0;
			hit_q <= 1'b0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			found_idx_q <= '0;
			free_idx_q <= '0;
			lru_idx_q <= '0;
			lru_timer_q <= LruStart;
			res_kind_q <= '0;
			res_addr_q <= '0;
			res_mac_q <= '0;
		end else begin
			// a raised request stays until the controller takes it
			if (cmd_i.emit) emit_q <= 1'b0;
			if (cmd_i.load) begin
				item_q <= in_data;
				hop_q <= ((in_data.dest_ip & cfg.net_mask) == (cfg.local_ip & cfg.net_mask))
					? in_data.dest_ip : cfg.gateway_ip;
				found_q <= 1'b0;
				free_found_q <= 1'b0;
				hit_q <= 1'b0;
				lru_idx_q <= '0;
				lru_timer_q <= LruStart;
			end
			if (cmd_i.scan) begin
				case (item_q.cmd)
					CMD_TICK: begin
						if (st == ST_RESOLVING) begin
							if (timer_q[cmd_i.idx] != 16'd0) begin
								timer_q[cmd_i.idx] <= timer_q[cmd_i.idx] - 16'd1;
							end else if (retries_q[cmd_i.idx] == 8'd0) begin
								state_q[cmd_i.idx] <= ST_FREE;
							end else begin
								emit_q <= 1'b1;
								res_kind_q <= KIND_REQUEST;
								res_addr_q <= eip;
								res_mac_q <= '0;
								retries_q[cmd_i.idx] <= retries_q[cmd_i.idx] - 8'd1;
								timer_q[cmd_i.idx] <= cfg.pending_timeout;
							end
						end else if (st == ST_OK) begin
							if (timer_q[cmd_i.idx] != 16'd0) begin
								timer_q[cmd_i.idx] <= timer_q[cmd_i.idx] - 16'd1;
							end else begin
								emit_q <= 1'b1;
								res_kind_q <= KIND_REQUEST;
								res_addr_q <= eip;
								res_mac_q <= '0;
								state_q[cmd_i.idx] <= ST_RESOLVING;
								timer_q[cmd_i.idx] <= cfg.pending_timeout;
								retries_q[cmd_i.idx] <= cfg.max_retries;
							end
						end
					end
					CMD_LEARN: begin
						if (!found_q) begin
							if (st != ST_FREE) begin
								if (eip == item_q.sender_ip) begin
									found_q <= 1'b1;
									found_idx_q <= cmd_i.idx;
								end else if (st == ST_OK && timer_q[cmd_i.idx] < lru_timer_q) begin
									lru_timer_q <= timer_q[cmd_i.idx];
									lru_idx_q <= cmd_i.idx;
								end
							end else if (!free_found_q) begin
								free_found_q <= 1'b1;
								free_idx_q <= cmd_i.idx;
							end
						end
					end
					CMD_RESOLVE: begin
						if (!hit_q && st == ST_OK && eip == hop_q) begin
							hit_q <= 1'b1;
							res_mac_q <= mac_q[cmd_i.idx];
						end
					end
					default: ;
				endcase
			end
			if (cmd_i.write_learn) begin
				ip_q[slot] <= item_q.sender_ip;
				mac_q[slot] <= item_q.sender_mac;
				state_q[slot] <= ST_OK;
				timer_q[slot] <= cfg.ok_timeout;
				retries_q[slot] <= cfg.max_retries;
			end
		end
	end

	assign status.cmd = item_q.cmd;
	assign status.accepted = (item_q.hw_type == HwEthernet) && (item_q.tgt_ip == cfg.local_ip);
	assign status.is_request = item_q.arp_op == OpRequest;
	assign status.is_learn_op = (item_q.arp_op == OpRequest) || (item_q.arp_op == OpReply);
	assign status.emit_ready = emit_q;

	// result selection for emit and finish
	always_comb begin
		res = '0;
		if (cmd_i.emit) begin
			res.kind = res_kind_q;
			res.addr = res_addr_q;
		end else if (cmd_i.finish) begin
			case (item_q.cmd)
				CMD_LEARN: begin
					res.kind = KIND_REPLY;
					res.addr = item_q.sender_ip;
					res.hw_addr = item_q.sender_mac;
				end
				CMD_RESOLVE: begin
					if (hit_q) begin
						res.kind = KIND_RESOLVED;
						res.addr = hop_q;
						res.hw_addr = res_mac_q;
					end else begin
						res.kind = KIND_REQUEST;
						res.addr = item_q.dest_ip;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== rtl/arp_ctrl.sv =====
`timescale 1ns / 1ps
module arp_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output arp_pkg::out_item_t out_data,
	input arp_pkg::dp_status_t status,
	input arp_pkg::out_item_t res,
	output arp_pkg::dp_cmd_t cmd_o
);
	import arp_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE, S_SCAN, S_DRAIN, S_FINAL
	} ctrl_state_t;

	ctrl_state_t state_q;
	logic [CntW-1:0] cnt_q;
	logic [ResW-1:0] nres_q;
	out_item_t pend_q;       // latest tick request, held so the last flag can go on it
	logic pend_valid_q;
	logic out_free;
	logic can_take;
	logic take;
	logic push_out;
	out_item_t push_data;

	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE);
	// a new request enters the hold register once the held one can leave
	assign can_take = !pend_valid_q || out_free;
	assign take = cmd_o.emit && (nres_q < ResW'(MaxResults));

	// sweep commands; the scan pauses while a raised request waits
	always_comb begin
		cmd_o = '0;
		cmd_o.load = in_valid && in_ready;
		cmd_o.idx = cnt_q[IdxW-1:0];
		cmd_o.scan = (state_q == S_SCAN) && !status.emit_ready;
		cmd_o.emit = (state_q == S_SCAN || state_q == S_DRAIN) && status.emit_ready
			&& can_take;
		cmd_o.finish = (state_q == S_FINAL);
		cmd_o.write_learn = (state_q == S_FINAL) && out_free && status.cmd == CMD_LEARN
			&& status.accepted && status.is_learn_op;
	end

	// item loaded into the output register this cycle
	always_comb begin
		push_out = 1'b0;
		push_data = '0;
		if (take && pend_valid_q) begin
			push_out = 1'b1;
			push_data = pend_q;
		end else if (state_q == S_FINAL && out_free) begin
			push_out = 1'b1;
			case (status.cmd)
				CMD_TICK: begin
					if (pend_valid_q) push_data = pend_q;
				end
				CMD_LEARN: begin
					if (status.accepted && status.is_request) push_data = res;
				end
				CMD_RESOLVE: begin
					push_data = res;
				end
				default: ;
			endcase
			push_data.last = 1'b1;
		end
	end

	// state, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			nres_q <= '0;
			pend_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			if (push_out) begin
				out_valid <= 1'b1;
				out_data <= push_data;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (take) begin
				pend_q <= res;
				pend_valid_q <= 1'b1;
				nres_q <= nres_q + ResW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_o.load) begin
						cnt_q <= '0;
						nres_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cmd_o.scan) begin
						if (cnt_q == CntW'(TableEntries - 1)) state_q <= S_DRAIN;
						else cnt_q <= cnt_q + CntW'(1);
					end
				end
				S_DRAIN: begin
					// the last entry may raise a request in the cycle after its scan
					if (!status.emit_ready) state_q <= S_FINAL;
				end
				S_FINAL: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// emitted results never exceed the cap
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= ResW'(MaxResults)) else $error("result count overflow");
	// items are only taken when idle
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_o.load |-> state_q == S_IDLE) else $error("load outside idle");
	// learn writes happen only in the final step
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_o.write_learn |-> cmd_o.finish) else $error("stray learn write");
	// a waiting result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while waiting");
endmodule

// ===== rtl/arp_cache_with_aging.sv =====
`timescale 1ns / 1ps
// ARP cache with aging. A controller sweeps the eight table entries through one
// compare-and-update datapath, one entry per cycle; a new item is taken only in
// idle, after the previous one has placed its final result in the output register,
// and the sweep pauses while a raised tick request waits or cannot move to the output
// register. A tick emits up to eight requests, a learned request one reply and a
// resolve one hit or request; every item ends with one result flagged last, of
// kind nothing when it emits no other. The user must write registers only between
// items; the block itself does not enforce it.
module arp_cache_with_aging (
	input logic clk,
	input logic arst_n,
	arp_in_if.sink in_ch,
	arp_out_if.source out_ch,
	arp_cfg_if.sink cfg_ch
);
	import arp_pkg::*;

	cfg_t cfg_q;
	dp_cmd_t dcmd;
	dp_status_t dstat;
	out_item_t res;

	assign cfg_ch.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_ip <= 32'd0;
			cfg_q.net_mask <= 32'hffffff00;
			cfg_q.gateway_ip <= 32'd0;
			cfg_q.ok_timeout <= 16'd5;
			cfg_q.pending_timeout <= 16'd1;
			cfg_q.max_retries <= 8'd5;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				REG_LOCAL_IP: cfg_q.local_ip <= cfg_ch.wdata;
				REG_NET_MASK: cfg_q.net_mask <= cfg_ch.wdata;
				REG_GATEWAY_IP: cfg_q.gateway_ip <= cfg_ch.wdata;
				REG_OK_TIMEOUT: cfg_q.ok_timeout <= cfg_ch.wdata[15:0];
				REG_PENDING_TIMEOUT: cfg_q.pending_timeout <= cfg_ch.wdata[15:0];
				REG_MAX_RETRIES: cfg_q.max_retries <= cfg_ch.wdata[7:0];
				default: ;
			endcase
		end
	end

	arp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_ch.data), .cfg(cfg_q),
		.cmd_i(dcmd), .status(dstat), .res(res)
	);

	arp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.status(dstat), .res(res), .cmd_o(dcmd)
	);
endmodule

// ===== test/arp_tb_checker.sv =====
`timescale 1ns / 1ps
module arp_tb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input arp_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input arp_pkg::out_item_t out_data,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_wdata,
	output int fail_count,
	output int pending_count,
	output int result_count
);
	import arp_pkg::*;

	// predictor copy of the registers and the table
	cfg_t regs;
	entry_state_t tbl_state [TableEntries];
	logic [31:0] tbl_ip [TableEntries];
	logic [47:0] tbl_mac [TableEntries];
	logic [15:0] tbl_timer [TableEntries];
	logic [7:0] tbl_retries [TableEntries];
	out_item_t expected_results [$];

	task automatic report(input string what, input out_item_t got, input out_item_t want);
		fail_count++;
		$display("mismatch %s: got k%0d a%h h%h l%0d want k%0d a%h h%h l%0d", what,
			got.kind, got.addr, got.hw_addr, got.last,
			want.kind, want.addr, want.hw_addr, want.last);
	endtask

	function automatic void push_result(inout out_item_t batch [$], input kind_t k,
			input logic [31:0] a, input logic [47:0] h);
		out_item_t r;
		if (batch.size() >= MaxResults) return;
		r.kind = k;
		r.addr = a;
		r.hw_addr = h;
		r.last = 1'b0;
		batch.push_back(r);
	endfunction

	// choose the slot for a learned sender
	function automatic int choose_slot(input logic [31:0] ip);
		int free_slot;
		int lru_slot;
		logic [15:0] lru_timer;
		free_slot = -1;
		lru_slot = 0;
		lru_timer = LruStart;
		for (int i = 0; i < TableEntries; i++) begin
			if (tbl_state[i] != ST_FREE) begin
				if (tbl_ip[i] == ip) return i;
				if (tbl_state[i] == ST_OK && tbl_timer[i] < lru_timer) begin
					lru_timer = tbl_timer[i];
					lru_slot = i;
				end
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		return (free_slot >= 0) ? free_slot : lru_slot;
	endfunction

	task automatic learn_sender(input logic [31:0] ip, input logic [47:0] mac);
		int s;
		s = choose_slot(ip);
		tbl_ip[s] = ip;
		tbl_mac[s] = mac;
		tbl_state[s] = ST_OK;
		tbl_timer[s] = regs.ok_timeout;
		tbl_retries[s] = regs.max_retries;
	endtask

	// work out the results of one accepted item
	task automatic predict_item(input in_item_t it);
		out_item_t batch [$];
		logic [31:0] hop;
		bit hit;
		hit = 0;
		case (cmd_t'(it.cmd))
			CMD_TICK: begin
				for (int i = 0; i < TableEntries; i++) begin
					if (tbl_state[i] == ST_RESOLVING) begin
						if (tbl_timer[i] > 0) tbl_timer[i]--;
						else if (tbl_retries[i] == 0) tbl_state[i] = ST_FREE;
						else begin
							push_result(batch, KIND_REQUEST, tbl_ip[i], '0);
							tbl_retries[i]--;
							tbl_timer[i] = regs.pending_timeout;
						end
					end else if (tbl_state[i] == ST_OK) begin
						if (tbl_timer[i] > 0) tbl_timer[i]--;
						else begin
							push_result(batch, KIND_REQUEST, tbl_ip[i], '0);
							tbl_state[i] = ST_RESOLVING;
							tbl_timer[i] = regs.pending_timeout;
							tbl_retries[i] = regs.max_retries;
						end
					end
				end
			end
			CMD_LEARN: begin
				if (it.hw_type == HwEthernet && it.tgt_ip == regs.local_ip) begin
					if (it.arp_op == OpRequest) begin
						push_result(batch, KIND_REPLY, it.sender_ip, it.sender_mac);
						learn_sender(it.sender_ip, it.sender_mac);
					end else if (it.arp_op == OpReply) begin
						learn_sender(it.sender_ip, it.sender_mac);
					end
				end
			end
			CMD_RESOLVE: begin
				hop = ((it.dest_ip & regs.net_mask) == (regs.local_ip & regs.net_mask))
					? it.dest_ip : regs.gateway_ip;
				for (int i = 0; i < TableEntries && !hit; i++) begin
					if (tbl_state[i] == ST_OK && tbl_ip[i] == hop) begin
						push_result(batch, KIND_RESOLVED, hop, tbl_mac[i]);
						hit = 1;
					end
				end
				if (!hit) push_result(batch, KIND_REQUEST, it.dest_ip, '0);
			end
			default: ;
		endcase
		if (batch.size() == 0) push_result(batch, KIND_NONE, '0, '0);
		batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i]) expected_results.push_back(batch[i]);
	endtask

	// watch the channels at each edge
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			regs.local_ip = '0;
			regs.net_mask = 32'hffffff00;
			regs.gateway_ip = '0;
			regs.ok_timeout = 16'd5;
			regs.pending_timeout = 16'd1;
			regs.max_retries = 8'd5;
			for (int i = 0; i < TableEntries; i++) begin
				tbl_state[i] = ST_FREE;
				tbl_ip[i] = '0;
				tbl_mac[i] = '0;
				tbl_timer[i] = '0;
				tbl_retries[i] = '0;
			end
			expected_results.delete();
			fail_count = 0;
			result_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_t'(cfg_index))
					REG_LOCAL_IP: regs.local_ip = cfg_wdata;
					REG_NET_MASK: regs.net_mask = cfg_wdata;
					REG_GATEWAY_IP: regs.gateway_ip = cfg_wdata;
					REG_OK_TIMEOUT: regs.ok_timeout = cfg_wdata[15:0];
					REG_PENDING_TIMEOUT: regs.pending_timeout = cfg_wdata[15:0];
					REG_MAX_RETRIES: regs.max_retries = cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				result_count++;
				if (expected_results.size() == 0) begin
					report("unexpected", out_data, '0);
				end else begin
					want = expected_results.pop_front();
					if (out_data.kind != want.kind) report("kind", out_data, want);
					else if (out_data.addr != want.addr) report("addr", out_data, want);
					else if (out_data.hw_addr != want.hw_addr) report("hw_addr", out_data, want);
					else if (out_data.last != want.last) report("last", out_data, want);
				end
			end
			if (in_valid && in_ready) predict_item(in_data);
			pending_count = expected_results.size();
		end
	end
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import arp_pkg::*;

	localparam int CycleLimit = 400000;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending_count;
	int result_count;
	int cycle_count;
	int items_sent;
	logic [31:0] my_ip;
	logic [31:0] known_ips [8];

	arp_in_if in_ch (clk);
	arp_out_if out_ch (clk);
	arp_cfg_if cfg_ch (clk);

	arp_cache_with_aging dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	arp_tb_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_data(in_ch.data),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_data(out_ch.data),
		.cfg_valid(cfg_ch.valid),
		.cfg_ready(cfg_ch.ready),
		.cfg_index(cfg_ch.index),
		.cfg_wdata(cfg_ch.wdata),
		.fail_count(fail_count),
		.pending_count(pending_count),
		.result_count(result_count)
	);

	// clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		int mode;
		mode = (cycle_count / 500) % 3;
		if (mode == 0) out_ch.ready <= 1'b1;
		else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
		else out_ch.ready <= ($urandom_range(0, 9) < 3) || (cycle_count % 17 == 0);
	end

	task automatic write_reg(input reg_t idx, input logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_count != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// send one item, with a random gap before bursts
	task automatic send(input in_item_t it);
		if ($urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	task automatic stop_sending();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_item_t make_item(input cmd_t c, input logic [15:0] hw,
			input logic [15:0] op, input logic [31:0] sip, input logic [47:0] smac,
			input logic [31:0] tip, input logic [31:0] dip);
		in_item_t it;
		it.cmd = c;
		it.hw_type = hw;
		it.arp_op = op;
		it.sender_ip = sip;
		it.sender_mac = smac;
		it.tgt_ip = tip;
		it.dest_ip = dip;
		return it;
	endfunction

	function automatic logic [47:0] rand_mac();
		return {16'($urandom()), $urandom()};
	endfunction

	// random phase with one setting
	task automatic random_phase(input int count);
		in_item_t it;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			it = make_item(CMD_TICK, 16'($urandom()), 16'($urandom()), $urandom(), rand_mac(),
				$urandom(), $urandom());
			if (pick < 25) begin
				it.cmd = CMD_TICK;
			end else if (pick < 60) begin
				it.cmd = CMD_LEARN;
				it.hw_type = HwEthernet;
				it.tgt_ip = my_ip;
				it.arp_op = ($urandom_range(0, 1) != 0) ? OpRequest : OpReply;
				it.sender_ip = known_ips[$urandom_range(0, 7)];
				if ($urandom_range(0, 9) == 0) it.sender_ip = $urandom();
				if ($urandom_range(0, 9) == 0) it.arp_op = 16'($urandom());
			end else if (pick < 90) begin
				it.cmd = CMD_RESOLVE;
				it.dest_ip = ($urandom_range(0, 3) != 0) ? known_ips[$urandom_range(0, 7)]
					: $urandom();
			end else if (pick < 97) begin
				it.cmd = CMD_LEARN;
				if ($urandom_range(0, 1) != 0) it.tgt_ip = my_ip;
			end else begin
				it.cmd = CMD_NONE;
			end
			send(it);
			if (n == count / 2) begin
				stop_sending();
				while (pending_count != 0) @(posedge clk);
			end
		end
		stop_sending();
	endtask

	task automatic set_regs(input logic [31:0] lip, input logic [31:0] mask,
			input logic [31:0] gw, input logic [15:0] okt, input logic [15:0] pt,
			input logic [7:0] mr);
		wait_idle();
		write_reg(REG_LOCAL_IP, lip);
		write_reg(REG_NET_MASK, mask);
		write_reg(REG_GATEWAY_IP, gw);
		write_reg(REG_OK_TIMEOUT, {16'd0, okt});
		write_reg(REG_PENDING_TIMEOUT, {16'd0, pt});
		write_reg(REG_MAX_RETRIES, {24'd0, mr});
		my_ip = lip;
		for (int i = 0; i < 8; i++) known_ips[i] = (lip & mask) | (i + 1);
		known_ips[7] = gw;
	endtask

	initial begin
		arst_n = 1'b0;
		cycle_count = 0;
		items_sent = 0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.wdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (5) @(posedge clk);

		// directed: learn request and reply, filters, fill and replace, resolve, aging
		set_regs(32'h0a000001, 32'hffffff00, 32'h0a0000fe, 16'd2, 16'd0, 8'd1);
		send(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0));
		send(make_item(CMD_LEARN, 16'd2, OpRequest, 32'h0a000002, 48'h1, 32'h0a000001, 0));
		send(make_item(CMD_LEARN, HwEthernet, OpRequest, 32'h0a000002,
			48'hffffffffffff, 32'h0a000001, 0));
		send(make_item(CMD_LEARN, HwEthernet, OpReply, 32'h0a0000fe, 48'h0,
			32'h0a000001, 0));
		send(make_item(CMD_LEARN, HwEthernet, 16'hffff, 32'h0a000009, 48'h5,
			32'h0a000001, 0));
		send(make_item(CMD_LEARN, HwEthernet, OpReply, 32'h0a000003, 48'h3, 32'h0, 0));
		send(make_item(CMD_RESOLVE, 0, 0, 0, 0, 0, 32'h0a000002));
		send(make_item(CMD_RESOLVE, 0, 0, 0, 0, 0, 32'h08080808));
		send(make_item(CMD_RESOLVE, 0, 0, 0, 0, 0, 32'h0a000077));
		send(make_item(CMD_NONE, 16'hffff, 16'hffff, '1, '1, '1, '1));
		for (int i = 0; i < 8; i++)
			send(make_item(CMD_LEARN, HwEthernet, OpReply, 32'h0a000010 + i, 48'h10 + i,
				32'h0a000001, 0));
		send(make_item(CMD_LEARN, HwEthernet, OpReply, 32'hffffffff, 48'hffffffffffff,
			32'h0a000001, 0));
		for (int i = 0; i < 6; i++) send(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0));
		stop_sending();

		// random phases across settings, extremes among them
		set_regs(32'hc0a80101, 32'hffffff00, 32'hc0a801fe, 16'd5, 16'd1, 8'd5);
		random_phase(70);
		set_regs(32'h0, 32'h0, 32'h0, 16'd0, 16'd0, 8'd0);
		random_phase(60);
		set_regs(32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, 8'hff);
		random_phase(50);
		set_regs($urandom(), 32'hfffff000, $urandom(), 16'd3, 16'd2, 8'd2);
		random_phase(70);
		set_regs(32'h0a0a0a0a, 32'hffff0000, 32'h0a0a0001, 16'd1, 16'd0, 8'd3);
		random_phase(50);

		while (pending_count != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("tb: %0d items sent, %0d results checked over six register settings",
			items_sent, result_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end
endmodule
